@@ src/sxr_rng_pkg.sv @@
// ----------------------------------------------------------------------------
// sxr_rng_pkg
// Types, constants and helpers for the seeded xorshift range generator.
// ----------------------------------------------------------------------------
`default_nettype none

package sxr_rng_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned CNT_W  = $clog2(WORD_W);

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [1:0]        mode_t;

	// Request codes
	localparam mode_t MODE_RESEED = 2'd0;
	localparam mode_t MODE_RAW    = 2'd1;
	localparam mode_t MODE_RANGE  = 2'd2;

	// Generator and hash constants
	localparam word_t RESET_STATE = 32'h1234_5678;
	localparam word_t HASH_XOR    = 32'd61;
	localparam word_t HASH_MUL_B  = 32'h27d4_eb2d;

	// Top-level sequencer
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HASH,
		ST_DIVIDE,
		ST_FINISH
	} ctrl_state_t;

	// One Wang hash operation per cycle
	typedef enum logic [2:0] {
		HS_SCALE,
		HS_FOLD16,
		HS_MUL9,
		HS_FOLD4,
		HS_MULB,
		HS_FOLD15
	} hash_step_t;

	// One xorshift32 step: left 13, right 17, left 5
	function automatic word_t xorshift32(input word_t s);
		word_t t;
		t = s ^ (s << 13);
		t = t ^ (t >> 17);
		t = t ^ (t << 5);
		return t;
	endfunction

endpackage

`default_nettype wire

@@ src/seeded_xorshift_range_rng_top.sv @@
// ----------------------------------------------------------------------------
// seeded_xorshift_range_rng_top
// 32-bit xorshift generator with Wang-hash reseeding and a bit-serial
// range reduction (remainder by a variable modulus).
// ----------------------------------------------------------------------------
//
//  Channel | Handshake            | Beat contents
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | mode, seed_value, range_low, range_modulus
//  out     | out_valid / out_ready| value, div_error
//
//  Modes 1 and 3 pass straight to the finish state; mode 0 steps the hash, one
//  hash operation per cycle; mode 2 runs the restoring divider shift registers,
//  one remainder bit per cycle, or passes straight on when the modulus is zero.
//  One item is in work at a time; in_ready is high only while the sequencer
//  idles. While the out channel stalls, one more item can be accepted and
//  finished; its result then waits in the finish state and the input stays
//  blocked until the output register frees. Reset loads the state word with
//  0x12345678 and clears all control.
//
`default_nettype none

module seeded_xorshift_range_rng_top (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_ready,
	input  wire  sxr_rng_pkg::mode_t mode,
	input  wire  sxr_rng_pkg::word_t seed_value,
	input  wire  sxr_rng_pkg::word_t range_low,
	input  wire  sxr_rng_pkg::word_t range_modulus,
	output logic                    out_valid,
	input  wire                     out_ready,
	output sxr_rng_pkg::word_t      value,
	output logic                    div_error
);
	import sxr_rng_pkg::*;

	ctrl_state_t state_q, state_d;
	hash_step_t  hstep_q;
	logic [CNT_W-1:0] count_q;

	word_t gen_q;      // generator state
	word_t work_q;     // hash operand / dividend shift register
	word_t rem_q;      // partial remainder
	word_t mod_q;      // divisor
	word_t res_q;      // finished value, waiting for the output register
	logic  err_q;

	logic  in_beat;
	logic  out_load;
	logic  hash_last;
	logic  div_last;

	word_t gen_next;
	word_t hash_next;
	logic [WORD_W:0] trial;
	logic [WORD_W:0] trial_diff;
	word_t rem_next;

	assign in_beat   = in_valid && in_ready;
	assign hash_last = (hstep_q == HS_FOLD15);
	assign div_last  = (count_q == CNT_W'(WORD_W - 1));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_beat) begin
					if (mode == MODE_RESEED) begin
						state_d = ST_HASH;
					end else if (mode == MODE_RANGE && range_modulus != '0) begin
						state_d = ST_DIVIDE;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_HASH: begin
				if (hash_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_DIVIDE: begin
				if (div_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_ready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_FINISH: out_load = !out_valid || out_ready;
			default: begin
				in_ready = 1'b0;
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// One hash operation on the work register
	always_comb begin
		hash_next = work_q;
		case (hstep_q)
			HS_SCALE:  hash_next = work_q + (work_q << 4);               // * 0x11
			HS_FOLD16: hash_next = (work_q ^ HASH_XOR) ^ (work_q >> 16);
			HS_MUL9:   hash_next = work_q + (work_q << 3);               // * 9
			HS_FOLD4:  hash_next = work_q ^ (work_q >> 4);
			HS_MULB:   hash_next = work_q * HASH_MUL_B;
			HS_FOLD15: hash_next = work_q ^ (work_q >> 15);
			default:   hash_next = work_q;
		endcase
	end

	// Restoring divider: one quotient bit per cycle
	assign trial      = {rem_q, work_q[WORD_W-1]};
	assign trial_diff = trial - {1'b0, mod_q};
	assign rem_next   = trial_diff[WORD_W] ? trial[WORD_W-1:0] : trial_diff[WORD_W-1:0];

	assign gen_next = xorshift32(gen_q);

	// Generator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= RESET_STATE;
		end else if (in_beat && (mode == MODE_RAW || mode == MODE_RANGE)) begin
			gen_q <= gen_next;
		end else if (state_q == ST_HASH && hash_last) begin
			gen_q <= hash_next;
		end
	end

	// Step counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hstep_q <= HS_SCALE;
			count_q <= '0;
		end else if (in_beat) begin
			hstep_q <= HS_SCALE;
			count_q <= '0;
		end else begin
			if (state_q == ST_HASH && !hash_last) begin
				hstep_q <= hash_step_t'(hstep_q + 3'd1);
			end
			if (state_q == ST_DIVIDE) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// Datapath: operands, remainder and finished result
	always_ff @(posedge clk) begin
		if (in_beat) begin
			rem_q <= '0;
			mod_q <= range_modulus;
			err_q <= 1'b0;
			if (mode == MODE_RESEED) begin
				work_q <= seed_value + 32'd1;
			end else begin
				work_q <= gen_next + range_low;
			end
			case (mode)
				MODE_RAW: res_q <= gen_next;
				MODE_RANGE: begin
					res_q <= '0;
					err_q <= (range_modulus == '0);
				end
				MODE_RESEED: res_q <= '0;
				default: res_q <= gen_q;
			endcase
		end else if (state_q == ST_HASH) begin
			work_q <= hash_next;
			if (hash_last) begin
				res_q <= hash_next;
			end
		end else if (state_q == ST_DIVIDE) begin
			work_q <= work_q << 1;
			rem_q  <= rem_next;
			if (div_last) begin
				res_q <= rem_next;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			value     <= res_q;
			div_error <= err_q;
		end
	end

endmodule

`default_nettype wire

@@ dv/sxr_rng_checker.sv @@
// ----------------------------------------------------------------------------
// sxr_rng_checker
// Passive checker for the seeded xorshift range generator. Mirrors the state
// word on every accepted request beat, queues the predicted result and
// compares each accepted result beat field by field against the oldest one.
// ----------------------------------------------------------------------------
`default_nettype none

module sxr_rng_checker (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	input  wire                      in_ready,
	input  wire  sxr_rng_pkg::mode_t mode,
	input  wire  sxr_rng_pkg::word_t seed_value,
	input  wire  sxr_rng_pkg::word_t range_low,
	input  wire  sxr_rng_pkg::word_t range_modulus,
	input  wire                      out_valid,
	input  wire                      out_ready,
	input  wire  sxr_rng_pkg::word_t value,
	input  wire                      div_error,
	output int                       fault_count,
	output int                       outstanding
);

	import sxr_rng_pkg::*;

	localparam word_t SEED_SCALE = 32'h11;
	localparam word_t HASH_MUL_A = 32'd9;

	typedef struct packed {
		word_t value;
		logic  div_error;
	} rng_beat_t;

	rng_beat_t predicted_beats[$];
	word_t     shadow_state;

	// xorshift32: left 13, right 17, left 5
	function automatic word_t xorshift_next(input word_t s);
		word_t t;
		t = s ^ {s[18:0], 13'd0};
		t = t ^ {17'd0, t[31:17]};
		t = t ^ {t[26:0], 5'd0};
		return t;
	endfunction

	// Wang integer hash, all products truncated to 32 bits
	function automatic word_t wang_scramble(input word_t x);
		word_t h;
		h = x ^ HASH_XOR ^ (x >> 16);
		h = h * HASH_MUL_A;
		h = h ^ (h >> 4);
		h = h * HASH_MUL_B;
		h = h ^ (h >> 15);
		return h;
	endfunction

	initial begin
		fault_count = 0;
		outstanding = 0;
	end

	// Predict on request beats, compare on result beats
	always @(posedge clk or negedge arst_n) begin : watch
		rng_beat_t want;
		word_t     offset_sum;
		if (!arst_n) begin
			shadow_state = RESET_STATE;
			predicted_beats.delete();
		end else begin
			if (in_valid && in_ready) begin
				want.div_error = 1'b0;
				case (mode)
					MODE_RESEED: begin
						shadow_state = wang_scramble((seed_value + 32'd1) * SEED_SCALE);
						want.value = shadow_state;
					end
					MODE_RAW: begin
						shadow_state = xorshift_next(shadow_state);
						want.value = shadow_state;
					end
					MODE_RANGE: begin
						shadow_state = xorshift_next(shadow_state);
						offset_sum = shadow_state + range_low;
						if (range_modulus == '0) begin
							want.value = '0;
							want.div_error = 1'b1;
						end else begin
							want.value = offset_sum % range_modulus;
						end
					end
					// spare code: state held, current word returned
					default: want.value = shadow_state;
				endcase
				predicted_beats.push_back(want);
			end

			if (out_valid && out_ready) begin
				if (predicted_beats.size() == 0) begin
					$display("%0t: result beat with nothing pending: value=%h div_error=%b",
						$time, value, div_error);
					fault_count++;
				end else begin
					want = predicted_beats.pop_front();
					if (value !== want.value) begin
						$display("%0t: value mismatch: expected %h actual %h",
							$time, want.value, value);
						fault_count++;
					end
					if (div_error !== want.div_error) begin
						$display("%0t: div_error mismatch: expected %b actual %b",
							$time, want.div_error, div_error);
						fault_count++;
					end
				end
			end
		end
		outstanding = predicted_beats.size();
	end

endmodule

`default_nettype wire

@@ dv/seeded_xorshift_range_rng_top_tb.sv @@
// ----------------------------------------------------------------------------
// seeded_xorshift_range_rng_top_tb
// Drives directed and random requests (reseed, raw word, range reduction and
// the spare code) into the generator with random idle bursts on both
// channels and one long result hold-off; the checker scores every result.
// ----------------------------------------------------------------------------
`default_nettype none

module seeded_xorshift_range_rng_top_tb;

	import sxr_rng_pkg::*;

	localparam mode_t MODE_SPARE     = 2'd3;
	// inverse of the seed scale 0x11 modulo 2^32
	localparam word_t SCALE_INVERSE  = 32'hf0f0_f0f1;
	// scaled seed equal to the hash xor constant folds to zero, and so does the hash
	localparam word_t ZERO_HASH_SEED = HASH_XOR * SCALE_INVERSE - 32'd1;
	localparam int    RANDOM_ITEMS   = 1250;
	localparam int    CALM_FROM      = 1100;
	localparam int    HOLD_AT        = 250;
	localparam int    LONG_HOLD      = 400;

	logic  clk;
	logic  arst_n;
	logic  in_valid;
	logic  in_ready;
	mode_t mode;
	word_t seed_value;
	word_t range_low;
	word_t range_modulus;
	logic  out_valid;
	logic  out_ready;
	word_t value;
	logic  div_error;
	int    fault_count;
	int    outstanding;

	// Sender and receiver pacing knobs
	int gap_odds = 4;
	bit calm = 1'b0;
	bit hold_results = 1'b0;

	seeded_xorshift_range_rng_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.seed_value   (seed_value),
		.range_low    (range_low),
		.range_modulus(range_modulus),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.value        (value),
		.div_error    (div_error)
	);

	sxr_rng_checker result_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.seed_value   (seed_value),
		.range_low    (range_low),
		.range_modulus(range_modulus),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.value        (value),
		.div_error    (div_error),
		.fault_count  (fault_count),
		.outstanding  (outstanding)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Run limit, far above the slowest legal run
	initial begin
		#4000000;
		$display("seeded_xorshift_range_rng_top_tb: errors");
		$finish;
	end

	// Offer one request beat, optionally after an idle burst; returns at the accepting edge
	task automatic offer_request(input mode_t m, input word_t seed, input word_t low,
			input word_t modulus);
		if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid      <= 1'b1;
		mode          <= m;
		seed_value    <= seed;
		range_low     <= low;
		range_modulus <= modulus;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Result side: ready stretches, short stall bursts, one long hold-off
	initial begin
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_results) begin
				hold_results = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	// Request side and verdict
	initial begin
		int    pick;
		mode_t m;
		word_t seed;
		word_t low;
		word_t modulus;

		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		mode          <= MODE_RESEED;
		seed_value    <= '0;
		range_low     <= '0;
		range_modulus <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: reset word, modulus extremes, wraps, seed extremes, zero hash
		offer_request(MODE_SPARE,  '0, '0, '0);
		offer_request(MODE_RAW,    '0, '0, '0);
		offer_request(MODE_RANGE,  '0, 32'h0000_1234, '0);
		offer_request(MODE_RANGE,  '0, 32'hffff_ffff, 32'd1);
		offer_request(MODE_RANGE,  '1, 32'hffff_ffff, 32'hffff_ffff);
		offer_request(MODE_RANGE,  '0, '0, 32'h8000_0000);
		offer_request(MODE_RANGE,  '0, 32'hffff_ffff, 32'd3);
		offer_request(MODE_RANGE,  '0, 32'h8000_0000, 32'hffff_fffe);
		offer_request(MODE_RESEED, '0, '1, '1);
		offer_request(MODE_RESEED, 32'hffff_ffff, '0, '0);
		offer_request(MODE_SPARE,  '1, '1, '1);
		offer_request(MODE_RESEED, 32'h7fff_ffff, '0, '0);
		offer_request(MODE_RAW,    '1, '1, '1);
		// zero state sticks under xorshift until the next reseed
		offer_request(MODE_RESEED, ZERO_HASH_SEED, '0, '0);
		offer_request(MODE_RAW,    '0, '0, '0);
		offer_request(MODE_RANGE,  '0, 32'd5, 32'd7);
		offer_request(MODE_RANGE,  '0, 32'd9, '0);
		offer_request(MODE_SPARE,  '0, '0, '0);
		offer_request(MODE_RESEED, 32'h8000_0000, '0, '0);
		offer_request(MODE_RANGE,  '0, '0, 32'h0000_ffff);

		// Random: weighted codes, moduli biased toward small and edge values
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 50 == 0) begin
				case ($urandom_range(0, 2))
					0: gap_odds = 0;
					1: gap_odds = 8;
					default: gap_odds = 3;
				endcase
			end
			if (i == HOLD_AT)
				hold_results = 1'b1;
			if (i == CALM_FROM)
				calm = 1'b1;

			pick = $urandom_range(0, 19);
			if (pick < 3)
				m = MODE_RESEED;
			else if (pick < 9)
				m = MODE_RAW;
			else if (pick < 18)
				m = MODE_RANGE;
			else
				m = MODE_SPARE;

			seed = ($urandom_range(0, 99) == 0) ? ZERO_HASH_SEED : $urandom;

			case ($urandom_range(0, 4))
				0: low = '0;
				1: low = 32'hffff_ffff - $urandom_range(0, 15);
				default: low = $urandom;
			endcase

			case ($urandom_range(0, 9))
				0: modulus = '0;
				1: modulus = $urandom_range(1, 16);
				2: modulus = 32'd1 << $urandom_range(0, 31);
				3: modulus = 32'hffff_ffff - $urandom_range(0, 15);
				4: modulus = $urandom_range(1, 65535);
				default: modulus = $urandom;
			endcase

			offer_request(m, seed, low, modulus);
		end
		in_valid <= 1'b0;

		// Drain, then allow for any stray result beat
		while (outstanding != 0) @(negedge clk);
		repeat (80) @(negedge clk);
		if (fault_count == 0 && outstanding == 0)
			$display("seeded_xorshift_range_rng_top_tb: clean");
		else
			$display("seeded_xorshift_range_rng_top_tb: errors");
		$finish;
	end

endmodule

`default_nettype wire
